// ===== hw/rtl/big_endian_sized_memory_assert.svh =====
// Assertion macros for the sized memory block.
`ifndef BIG_ENDIAN_SIZED_MEMORY_ASSERT_SVH
`define BIG_ENDIAN_SIZED_MEMORY_ASSERT_SVH

// same-cycle implication
`define BESM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BESM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/besm_pkg.sv =====
package besm_pkg;

   localparam int MEM_BYTES      = 65536;
   localparam int ADDR_BITS      = 24;
   localparam int BYTE_BITS      = 8;
   localparam int LANES          = 4;
   localparam int LANE_BITS      = $clog2(LANES);
   localparam int DATA_BITS      = LANES * BYTE_BITS;
   localparam int ROW_DEPTH      = MEM_BYTES / LANES;
   localparam int ROW_BITS       = $clog2(ROW_DEPTH);
   localparam int CSR_BITS       = 17;
   localparam int MEM_SIZE_RESET = 65536;
   localparam int LIMIT_BITS     = ADDR_BITS + 1;
   localparam int COUNT_BITS     = LANE_BITS + 1;

   typedef enum logic [1:0] {
      SZ_ONE  = 2'd0,
      SZ_TWO  = 2'd1,
      SZ_FOUR = 2'd2,
      SZ_BAD  = 2'd3
   } size_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_SIZE   = 2'd1,
      ST_MISALIGNED = 2'd2,
      ST_RANGE      = 2'd3
   } status_type;

   function automatic logic [COUNT_BITS-1:0] access_len(input size_type code);
      logic [COUNT_BITS-1:0] n;
      case (code)
         SZ_ONE:  n = COUNT_BITS'(1);
         SZ_TWO:  n = COUNT_BITS'(2);
         SZ_FOUR: n = COUNT_BITS'(4);
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/besm_ram.sv =====
module besm_ram #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             en,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_array [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_array[addr] <= wdata;
         end else begin
            rdata_ff <= mem_array[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/big_endian_sized_memory.sv =====
// Big-endian byte-addressed memory with size, alignment and range checks.
// Request channel (req_*): one access per item, read or write of 1, 2 or 4
// bytes. The address is masked to its low 24 bits; the lowest-addressed byte
// is the most significant. Result channel (rsp_*): one item per request with
// read data (zero for writes and rejected accesses) and a status code.
// Storage is four byte-wide lane RAMs, so any legal access touches each lane
// at most once and completes in one RAM access.
// An accepted item is read into the lane RAM output registers and is then
// registered again in the result register that drives rsp_*.
// Throughput: one item per cycle while the result side keeps up.
// csr_wr_en/csr_wr_data set the usable size in bytes; it saturates at the
// storage depth. Write it only while the block is idle.
// Reset clears the pipeline valids and sets the size to 65536; memory
// contents are not cleared and read as garbage until written.
// When rsp_stall is high the result holds, one more item can sit in the RAM
// read stage, and after that req_stall rises until the result is taken.
module big_endian_sized_memory (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic [31:0]                         req_address,
   input  logic [1:0]                          req_size_code,
   input  logic [besm_pkg::DATA_BITS-1:0]      req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [besm_pkg::DATA_BITS-1:0]      rsp_read_data,
   output logic [1:0]                          rsp_status,
   input  logic                                csr_wr_en,
   input  logic [besm_pkg::CSR_BITS-1:0]       csr_wr_data
);

   localparam int ADDR_BITS  = besm_pkg::ADDR_BITS;
   localparam int LANES      = besm_pkg::LANES;
   localparam int LANE_BITS  = besm_pkg::LANE_BITS;
   localparam int ROW_BITS   = besm_pkg::ROW_BITS;
   localparam int BYTE_BITS  = besm_pkg::BYTE_BITS;
   localparam int DATA_BITS  = besm_pkg::DATA_BITS;
   localparam int LIMIT_BITS = besm_pkg::LIMIT_BITS;
   localparam int COUNT_BITS = besm_pkg::COUNT_BITS;

   logic [besm_pkg::CSR_BITS-1:0] mem_size_ff;
   logic                          s1_valid_ff;
   logic                          s1_read_ff;
   logic [LANE_BITS-1:0]          s1_lo_ff;
   logic [COUNT_BITS-1:0]         s1_bytes_ff;
   besm_pkg::status_type          s1_status_ff;
   logic                          rsp_valid_ff;
   logic [DATA_BITS-1:0]          rsp_read_data_ff;
   besm_pkg::status_type          rsp_status_ff;

   logic                          accept;
   logic                          s1_adv;
   logic [ADDR_BITS-1:0]          addr_m;
   logic [LANE_BITS-1:0]          addr_lo;
   logic [ROW_BITS-1:0]           row_base;
   logic [COUNT_BITS-1:0]         nbytes;
   logic [LIMIT_BITS-1:0]         limit;
   logic [LIMIT_BITS-1:0]         last_end;
   besm_pkg::status_type          status_in;
   logic                          access_ok;

   logic [LANE_BITS-1:0]          lane_ofs   [LANES];
   logic [COUNT_BITS-1:0]         lane_shift [LANES];
   logic [ROW_BITS-1:0]           lane_row   [LANES];
   logic                          lane_we    [LANES];
   logic [BYTE_BITS-1:0]          lane_wd    [LANES];
   logic [BYTE_BITS-1:0]          lane_q     [LANES];

   logic [DATA_BITS-1:0]          rd_asm;

   assign accept  = req_valid && !req_stall;
   assign s1_adv  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;

   assign addr_m   = req_address[ADDR_BITS-1:0];
   assign addr_lo  = addr_m[LANE_BITS-1:0];
   assign row_base = addr_m[ROW_BITS+LANE_BITS-1:LANE_BITS];
   assign nbytes   = besm_pkg::access_len(besm_pkg::size_type'(req_size_code));

   // usable size is the size register clamped to the storage depth
   assign limit = (LIMIT_BITS'(mem_size_ff) > LIMIT_BITS'(besm_pkg::MEM_BYTES))
                ? LIMIT_BITS'(besm_pkg::MEM_BYTES) : LIMIT_BITS'(mem_size_ff);
   assign last_end = {1'b0, addr_m} + LIMIT_BITS'(nbytes);

   always_comb begin
      if (nbytes == '0) begin
         status_in = besm_pkg::ST_BAD_SIZE;
      end else if (nbytes > COUNT_BITS'(1) && addr_m[0]) begin
         status_in = besm_pkg::ST_MISALIGNED;
      end else if (last_end > limit) begin
         status_in = besm_pkg::ST_RANGE;
      end else begin
         status_in = besm_pkg::ST_OK;
      end
   end

   assign access_ok = accept && (status_in == besm_pkg::ST_OK);

   // byte i of the access lands in lane (addr + i) mod LANES; lanes below the
   // start lane wrap into the next row
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         lane_ofs[l]   = LANE_BITS'(l) - addr_lo;
         lane_shift[l] = nbytes - COUNT_BITS'(1) - COUNT_BITS'(lane_ofs[l]);
         lane_row[l]   = row_base + ROW_BITS'(LANE_BITS'(l) < addr_lo);
         lane_we[l]    = req_action && (COUNT_BITS'(lane_ofs[l]) < nbytes);
         lane_wd[l]    = req_write_data[BYTE_BITS*lane_shift[l][LANE_BITS-1:0] +: BYTE_BITS];
      end
   end

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      besm_ram #(
         .DEPTH (besm_pkg::ROW_DEPTH),
         .WIDTH (BYTE_BITS)
      ) u_ram (
         .clock (clock),
         .en    (access_ok),
         .we    (lane_we[g]),
         .addr  (lane_row[g]),
         .wdata (lane_wd[g]),
         .rdata (lane_q[g])
      );
   end

   always_comb begin
      rd_asm = '0;
      for (int i = 0; i < LANES; i++) begin
         if (COUNT_BITS'(i) < s1_bytes_ff) begin
            rd_asm = {rd_asm[DATA_BITS-BYTE_BITS-1:0],
                      lane_q[s1_lo_ff + LANE_BITS'(i)]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_size_ff  <= besm_pkg::CSR_BITS'(besm_pkg::MEM_SIZE_RESET);
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mem_size_ff <= csr_wr_data;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_read_ff   <= !req_action && (status_in == besm_pkg::ST_OK);
         s1_lo_ff     <= addr_lo;
         s1_bytes_ff  <= nbytes;
         s1_status_ff <= status_in;
      end
      if (s1_adv && s1_valid_ff) begin
         rsp_read_data_ff <= s1_read_ff ? rd_asm : '0;
         rsp_status_ff    <= s1_status_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

// ===== hw/rtl/besm_checker.sv =====
`include "big_endian_sized_memory_assert.svh"

module besm_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [besm_pkg::DATA_BITS-1:0]  rsp_read_data,
   input logic [1:0]                      rsp_status
);

   // a stalled result item holds
   `BESM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_read_data) && $stable(rsp_status), "stalled result item changed")

   // rejected accesses return no data
   `BESM_ASSERT_IMP(a_err_zero, clock, reset, rsp_valid && rsp_status != besm_pkg::ST_OK, rsp_read_data == '0, "rejected access returned data")

   // input only backs up behind a stalled result
   `BESM_ASSERT_IMP(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled result")

   // reset empties the pipeline
   `BESM_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall, "result pending after reset")

endmodule

bind big_endian_sized_memory besm_checker u_besm_checker (.*);

// ===== tb/tb_big_endian_sized_memory.sv =====
`timescale 1ns / 100ps

module tb_big_endian_sized_memory;

   localparam int   DATA_BITS      = besm_pkg::DATA_BITS;
   localparam int   CSR_BITS       = besm_pkg::CSR_BITS;
   localparam int   ADDR_BITS      = besm_pkg::ADDR_BITS;
   localparam int   MEM_BYTES      = besm_pkg::MEM_BYTES;
   localparam int   MEM_SIZE_RESET = besm_pkg::MEM_SIZE_RESET;
   localparam logic RD          = 1'b0;
   localparam logic WR          = 1'b1;
   localparam int   CYCLE_LIMIT = 200000;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_action     = 1'b0;
   logic [31:0]          req_address    = '0;
   logic [1:0]           req_size_code  = '0;
   logic [DATA_BITS-1:0] req_write_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [DATA_BITS-1:0] rsp_read_data;
   logic [1:0]           rsp_status;
   logic                 csr_wr_en      = 1'b0;
   logic [CSR_BITS-1:0]  csr_wr_data    = '0;

   bit no_gaps = 1'b0;
   int cycles  = 0;

   class mem_scoreboard;
      typedef struct packed {
         logic [DATA_BITS-1:0] read_data;
         besm_pkg::status_type status;
      } access_result_type;

      logic [7:0]        image  [MEM_BYTES];
      bit                filled [MEM_BYTES];
      int                mem_size;
      access_result_type expected_q[$];
      int                errors;

      function new();
         mem_size = MEM_SIZE_RESET;
         errors   = 0;
      endfunction

      function int usable_bytes();
         return (mem_size > MEM_BYTES) ? MEM_BYTES : mem_size;
      endfunction

      function int byte_count(besm_pkg::size_type sz);
         case (sz)
            besm_pkg::SZ_ONE:  return 1;
            besm_pkg::SZ_TWO:  return 2;
            besm_pkg::SZ_FOUR: return 4;
            default:           return 0;
         endcase
      endfunction

      // size first, then alignment, then range
      function besm_pkg::status_type judge(logic [31:0] addr, besm_pkg::size_type sz);
         logic [ADDR_BITS-1:0] a;
         int                   n;
         a = addr[ADDR_BITS-1:0];
         n = byte_count(sz);
         if (n == 0) return besm_pkg::ST_BAD_SIZE;
         if (n > 1 && a[0]) return besm_pkg::ST_MISALIGNED;
         if (longint'(a) + n > usable_bytes()) return besm_pkg::ST_RANGE;
         return besm_pkg::ST_OK;
      endfunction

      function bit reads_unwritten(logic [31:0] addr, besm_pkg::size_type sz);
         int a;
         if (judge(addr, sz) != besm_pkg::ST_OK) return 1'b0;
         a = int'(addr[ADDR_BITS-1:0]);
         for (int i = 0; i < byte_count(sz); i++)
            if (!filled[a + i]) return 1'b1;
         return 1'b0;
      endfunction

      function void note_access(logic act, logic [31:0] addr, besm_pkg::size_type sz,
                                logic [DATA_BITS-1:0] wd);
         access_result_type r;
         int                a;
         int                n;
         r.read_data = '0;
         r.status    = judge(addr, sz);
         a = int'(addr[ADDR_BITS-1:0]);
         n = byte_count(sz);
         if (r.status == besm_pkg::ST_OK) begin
            for (int i = 0; i < n; i++) begin
               if (act == WR) begin
                  // lowest address takes the most significant byte
                  image[a + i]  = wd[8 * (n - 1 - i) +: 8];
                  filled[a + i] = 1'b1;
               end else begin
                  r.read_data = {r.read_data[DATA_BITS-9:0], image[a + i]};
               end
            end
         end
         expected_q.push_back(r);
      endfunction

      function void check_result(logic [DATA_BITS-1:0] rd, logic [1:0] st);
         access_result_type r;
         if (expected_q.size() == 0) begin
            $error("result item with no access pending: read_data %h status %0d", rd, st);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         if (rd !== r.read_data) begin
            $error("read_data: expected %h, actual %h", r.read_data, rd);
            errors++;
         end
         if (st !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, st);
            errors++;
         end
      endfunction
   endclass

   mem_scoreboard sb;

   big_endian_sized_memory dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_address    (req_address),
      .req_size_code  (req_size_code),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !no_gaps && ($urandom_range(99) < 37);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         sb.check_result(rsp_read_data, rsp_status);
      end
   end

   // entered and left just after a falling edge
   task automatic send_access(input logic act, input logic [31:0] addr,
                              input besm_pkg::size_type sz,
                              input logic [DATA_BITS-1:0] wd);
      while (!no_gaps && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_address    <= addr;
      req_size_code  <= sz;
      req_write_data <= wd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_access(act, addr, sz, wd);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_mem_size(input logic [CSR_BITS-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.mem_size = int'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_access();
      logic [31:0]          addr;
      logic [DATA_BITS-1:0] wd;
      logic                 act;
      besm_pkg::size_type   sz;
      int                   lim;
      int                   pick;
      int                   roll;
      lim  = sb.usable_bytes();
      pick = $urandom_range(99);
      roll = $urandom_range(99);
      if (roll < 8)       sz = besm_pkg::SZ_BAD;
      else if (roll < 40) sz = besm_pkg::SZ_ONE;
      else if (roll < 70) sz = besm_pkg::SZ_TWO;
      else                sz = besm_pkg::SZ_FOUR;
      // two in five picks go to a small window that fills up fast, so reads find data
      if (pick < 40)      addr = $urandom_range(63);
      else if (pick < 60) addr = (lim > 8) ? lim - $urandom_range(8, 1) : $urandom_range(7);
      else if (pick < 75) addr = $urandom();
      else                addr = $urandom_range((lim > 0) ? lim - 1 : 0, 0);
      if (pick >= 75 || pick < 60) begin
         if ($urandom_range(1)) addr[31:24] = 8'($urandom());
      end
      if (sz != besm_pkg::SZ_ONE && $urandom_range(99) < 85) addr[0] = 1'b0;
      act = 1'($urandom_range(1));
      wd  = $urandom();
      if (act == RD && sb.reads_unwritten(addr, sz)) act = WR;
      send_access(act, addr, sz, wd);
   endtask

   task automatic run_phase(input logic [CSR_BITS-1:0] value, input int count,
                            input bit stretch, input bit pause);
      int k;
      set_mem_size(value);
      for (k = 0; k < count; k++) begin
         no_gaps = stretch && k >= 40 && k < 220;
         if (pause && k == count / 2) drain();
         random_access();
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset size, full storage
      send_access(WR, 32'h0000_0000, besm_pkg::SZ_FOUR, 32'h1122_3344);
      send_access(RD, 32'h0000_0000, besm_pkg::SZ_FOUR, 32'h0);
      send_access(RD, 32'h0000_0001, besm_pkg::SZ_ONE,  32'h0);
      send_access(RD, 32'hFF00_0002, besm_pkg::SZ_TWO,  32'hFFFF_FFFF);
      send_access(WR, 32'hFF00_FFFF, besm_pkg::SZ_ONE,  32'hFFFF_FFA5);
      send_access(RD, 32'h0000_FFFF, besm_pkg::SZ_ONE,  32'h0);
      send_access(WR, 32'h0000_FFFF, besm_pkg::SZ_TWO,  32'h0000_1234);
      send_access(WR, 32'h0000_FFFE, besm_pkg::SZ_TWO,  32'h0000_BEEF);
      send_access(WR, 32'h0000_FFFC, besm_pkg::SZ_FOUR, 32'hFFFF_FFFF);
      send_access(RD, 32'h0000_FFFC, besm_pkg::SZ_FOUR, 32'h0);
      send_access(WR, 32'h0000_FFFE, besm_pkg::SZ_FOUR, 32'h0);
      send_access(RD, 32'h0001_0000, besm_pkg::SZ_ONE,  32'h0);
      send_access(WR, 32'h00FF_FFFF, besm_pkg::SZ_ONE,  32'h0);
      send_access(RD, 32'hFFFF_FFFF, besm_pkg::SZ_BAD,  32'hFFFF_FFFF);
      send_access(WR, 32'h0001_0001, besm_pkg::SZ_FOUR, 32'h0);
      send_access(WR, 32'h0000_0004, besm_pkg::SZ_FOUR, 32'h0);
      send_access(WR, 32'h0000_0008, besm_pkg::SZ_TWO,  32'hFFFF_FFFF);
      send_access(RD, 32'h0000_0008, besm_pkg::SZ_TWO,  32'h0);

      // zero size rejects every well-formed access
      set_mem_size(17'd0);
      send_access(RD, 32'h0000_0000, besm_pkg::SZ_ONE,  32'h0);
      send_access(WR, 32'h0000_0000, besm_pkg::SZ_FOUR, 32'hDEAD_BEEF);
      send_access(WR, 32'h0000_0001, besm_pkg::SZ_TWO,  32'h0);
      send_access(RD, 32'h0000_0000, besm_pkg::SZ_BAD,  32'h0);

      // tiny size: last byte must sit below 5
      set_mem_size(17'd5);
      send_access(RD, 32'h0000_0000, besm_pkg::SZ_FOUR, 32'h0);
      send_access(RD, 32'h0000_0002, besm_pkg::SZ_FOUR, 32'h0);
      send_access(RD, 32'h0000_0004, besm_pkg::SZ_ONE,  32'h0);
      send_access(WR, 32'h0000_0005, besm_pkg::SZ_ONE,  32'h0);
      send_access(WR, 32'h0000_0004, besm_pkg::SZ_TWO,  32'h0);

      run_phase(17'h1FFFF, 280, 1'b0, 1'b1);
      run_phase(17'd65536, 280, 1'b1, 1'b0);
      run_phase(17'd300,   280, 1'b0, 1'b0);
      run_phase(17'd0,     60,  1'b0, 1'b0);
      run_phase(17'd65535, 280, 1'b0, 1'b0);
      run_phase(CSR_BITS'($urandom_range(17'h1FFFF)), 280, 1'b0, 1'b0);

      drain();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/besm_pkg.sv
hw/rtl/besm_ram.sv
hw/rtl/big_endian_sized_memory.sv
hw/rtl/besm_checker.sv
tb/tb_big_endian_sized_memory.sv
